>>> hdl/rff_pkg.sv
package rff_pkg;

  // field widths of the pixel and weight formats
  localparam int PIXEL_BITS       = 16;
  localparam int WEIGHT_BITS      = 17;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int TAP_IDX_BITS     = 6;
  localparam int COL_BITS         = 12;
  localparam int SIZE_BITS        = 13;
  localparam int RADIUS_BITS      = 5;
  localparam int MAX_WIDTH        = 4096;
  localparam int MAX_ROWS         = 4096;
  localparam int DEF_MAX_RADIUS   = 31;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RADIUS       = 2'd0,
    CFG_ROW_WIDTH    = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_t;

  // input word kinds
  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_PIXEL  = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [TAP_IDX_BITS-1:0] tap_index;
    logic [WEIGHT_BITS-1:0]  tap_weight;
    logic [PIXEL_BITS-1:0]   pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] filtered;
    logic [COL_BITS-1:0]   out_column;
    logic                  saturated;
    logic                  last_of_run;
    logic                  row_end;
    logic                  frame_end;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic weight_wr;
    logic pixel_wr;
    logic start_run;
    logic issue;
    logic load_out;
    logic next_x;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pixel;
    logic run_needed;
    logic k_last;
    logic x_last;
    logic pipe_busy;
    logic out_free;
  } ctrl_stat_t;

endpackage

>>> hdl/rff_ram.sv
module rff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rff_ctrl.sv
module rff_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rff_pkg::ctrl_stat_t stat,
  output rff_pkg::ctrl_cmd_t  cmd
);
  import rff_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat.is_pixel) begin
            cmd.pixel_wr = 1'b1;
            if (stat.run_needed) begin
              cmd.start_run = 1'b1;
              state_next    = ST_ISSUE;
            end
          end else begin
            cmd.weight_wr = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat.k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy && stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.x_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.next_x = 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/rff_datapath.sv
module rff_datapath #(
  parameter int MAX_RADIUS = rff_pkg::DEF_MAX_RADIUS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rff_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rff_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  rff_pkg::in_item_t                   in_data,
  output rff_pkg::out_item_t                  out_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  rff_pkg::ctrl_cmd_t                  cmd,
  output rff_pkg::ctrl_stat_t                 stat
);
  import rff_pkg::*;

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(WIN);
  localparam int DEPTH = 2 ** AW;
  localparam int PRODW = PIXEL_BITS + WEIGHT_BITS;
  localparam int ACCW  = PRODW + AW;
  localparam int SCOLW = COL_BITS + 2;

  // configuration registers
  logic [RADIUS_BITS-1:0] radius_q;
  logic [SIZE_BITS-1:0]   width_q;
  logic [SIZE_BITS-1:0]   height_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_q <= RADIUS_BITS'(1);
      width_q  <= SIZE_BITS'(1024);
      height_q <= SIZE_BITS'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS:       radius_q <= cfg_data[RADIUS_BITS-1:0];
        CFG_ROW_WIDTH:    width_q  <= cfg_data[SIZE_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes and radius
  logic [SIZE_BITS-1:0] w_eff, h_eff;
  logic [AW-1:0]        r_eff;

  always_comb begin
    if (width_q == '0) w_eff = SIZE_BITS'(1);
    else if (width_q > SIZE_BITS'(MAX_WIDTH)) w_eff = SIZE_BITS'(MAX_WIDTH);
    else w_eff = width_q;
    if (height_q == '0) h_eff = SIZE_BITS'(1);
    else if (height_q > SIZE_BITS'(MAX_ROWS)) h_eff = SIZE_BITS'(MAX_ROWS);
    else h_eff = height_q;
    if (int'(radius_q) > MAX_RADIUS) r_eff = AW'(MAX_RADIUS);
    else r_eff = AW'(radius_q);
  end

  // row and column position
  logic [COL_BITS-1:0] column_count, row_count;
  logic                row_last, col_last, row_is_last, early;
  logic [COL_BITS-1:0] first_x;

  assign col_last    = ({1'b0, column_count} + SIZE_BITS'(1)) >= w_eff;
  assign row_is_last = ({1'b0, row_count} + SIZE_BITS'(1)) >= h_eff;
  assign early       = column_count < COL_BITS'(r_eff);
  assign first_x     = early ? '0 : column_count - COL_BITS'(r_eff);
  assign row_last    = col_last && row_is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.pixel_wr) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_is_last ? '0 : row_count + COL_BITS'(1);
      end else begin
        column_count <= column_count + COL_BITS'(1);
      end
    end
  end

  // pixel ring write pointer
  logic [AW-1:0] wp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (cmd.pixel_wr) begin
      wp <= wp + AW'(1);
    end
  end

  // run bookkeeping
  logic [COL_BITS-1:0] c_run, x, x_end;
  logic [AW-1:0]       k, r_run, two_r;
  logic                last_run, frame_run;

  assign two_r = {r_run[AW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      c_run     <= column_count;
      x         <= first_x;
      x_end     <= col_last ? column_count : first_x;
      r_run     <= r_eff;
      last_run  <= col_last;
      frame_run <= row_last;
    end else if (cmd.next_x) begin
      x <= x + COL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= (k == two_r) ? '0 : k + AW'(1);
    end
  end

  // clamped column of this tap and its place in the ring
  logic signed [SCOLW-1:0] col;
  logic [COL_BITS-1:0]     col_c, idx;
  logic [AW-1:0]           pix_raddr;

  always_comb begin
    col = $signed({2'b00, x}) + $signed(SCOLW'(k)) - $signed(SCOLW'(r_run));
    if (col < 0) col_c = '0;
    else if (col > $signed({2'b00, c_run})) col_c = c_run;
    else col_c = col[COL_BITS-1:0];
    idx       = c_run - col_c;
    pix_raddr = wp - idx[AW-1:0];
  end

  // sample ring and tap table
  logic [PIXEL_BITS-1:0]  pix_rd;
  logic [WEIGHT_BITS-1:0] wgt_rd;
  logic                   wgt_wr;
  logic [AW-1:0]          tap_addr;
  logic [WIN-1:0]         wgt_valid;
  logic                   wval_q;

  assign wgt_wr   = cmd.weight_wr && (int'(in_data.tap_index) < WIN);
  assign tap_addr = AW'(in_data.tap_index);

  rff_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_pix_ram (
    .clk   (clk),
    .we    (cmd.pixel_wr),
    .waddr (wp + AW'(1)),
    .wdata (in_data.pixel),
    .raddr (pix_raddr),
    .rdata (pix_rd)
  );

  rff_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_wr),
    .waddr (tap_addr),
    .wdata (in_data.tap_weight),
    .raddr (k),
    .rdata (wgt_rd)
  );

  // tap valid bits: an unwritten tap reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      wgt_valid <= '0;
    end else if (wgt_wr) begin
      wgt_valid[tap_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    wval_q <= wgt_valid[k];
  end

  // multiply and accumulate pipeline
  logic             v1, v2;
  logic [PRODW-1:0] prod;
  logic [ACCW-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PRODW'(pix_rd) * PRODW'(wval_q ? wgt_rd : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.start_run || cmd.next_x) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACCW'(prod);
    end
  end

  // rounding and saturation
  logic [ACCW:0]                  rsum;
  logic [ACCW-WEIGHT_FRAC_BITS:0] q;
  logic                           sat;

  assign rsum = {1'b0, acc} + (ACCW+1)'(1 << (WEIGHT_FRAC_BITS - 1));
  assign q    = rsum[ACCW:WEIGHT_FRAC_BITS];
  assign sat  = |q[ACCW-WEIGHT_FRAC_BITS:PIXEL_BITS];

  // output register
  logic x_fin;

  assign x_fin = (x == x_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.filtered    <= sat ? '1 : q[PIXEL_BITS-1:0];
      out_data.out_column  <= x;
      out_data.saturated   <= sat;
      out_data.last_of_run <= x_fin;
      out_data.row_end     <= x_fin && last_run;
      out_data.frame_end   <= x_fin && frame_run;
    end
  end

  // status
  always_comb begin
    stat.is_pixel   = (in_data.cmd == CMD_PIXEL);
    stat.run_needed = col_last || !early;
    stat.k_last     = (k == two_r);
    stat.x_last     = x_fin;
    stat.pipe_busy  = v1 || v2;
    stat.out_free   = !out_valid || out_ready;
  end

  // checks
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> k <= two_r)
    else $error("tap counter beyond window");

  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !v1 && !v2)
    else $error("word loaded before accumulation finished");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.start_run |=> k == '0 && acc == '0)
    else $error("run did not start from a clear accumulator");

  a_x_in_run: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> x <= x_end)
    else $error("output column past end of run");

endmodule

>>> hdl/row_fir_filter_replicate_border.sv
// Horizontal FIR over a raster pixel stream with replicated borders. A weight
// word (cmd 0) stores one Q1.16 tap. A pixel word (cmd 1) is written into a
// sample ring and, once column x+radius is in (or at the row's last pixel, for
// every column still pending), one output per column is computed by a single
// multiply-accumulate unit reading the sample ring and the tap table one tap
// per cycle: each output takes 2*radius+1 taps and then a pipeline drain, and a
// pixel with outputs holds the input until its last output is loaded into the
// output register, which waits while the output side stalls.
// A pixel with no output and a weight word are taken at one per cycle.
module row_fir_filter_replicate_border #(
  parameter int MAX_RADIUS = rff_pkg::DEF_MAX_RADIUS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rff_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rff_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rff_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rff_pkg::out_item_t                out_data
);
  import rff_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencer
  rff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and storage
  rff_datapath #(.MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
